// ===== hdl/cartesian_polar_converter_assert.svh =====
// Assertion macros for the Cartesian/polar converter.
`ifndef CARTESIAN_POLAR_CONVERTER_ASSERT_SVH
`define CARTESIAN_POLAR_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication: ante holds at an edge, so does cons.
`define CPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication: ante at one edge, cons at the following one.
`define CPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define CPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/cpc_pkg.sv =====
// Shared types, constants and the arctangent table of the converter.
package cpc_pkg;

	// CORDIC datapath width: coordinates scaled by 2^24 plus gain headroom
	localparam int CW          = 58;
	localparam int GUARD_SHIFT = 24;

	// one square-root digit per step stage; this sets the step count
	localparam int SQRT_STEPS  = 32;
	localparam int PREP_STAGES = 3;
	localparam int POST_STAGES = 3;

	localparam logic [31:0] TURN_QUARTER  = 32'h4000_0000;
	localparam logic [31:0] TURN_HALF     = 32'h8000_0000;
	localparam logic [31:0] TURN_3QUARTER = 32'hC000_0000;

	// 1/K in Q32, start length of the rotation
	localparam logic signed [CW-1:0] INV_GAIN = CW'(32'h9B74_EDA8);

	typedef struct packed {
		logic                 mode;
		logic signed [31:0]   x;
		logic signed [31:0]   y;
		logic [30:0]          r;
		logic [31:0]          t;
		logic                 special;
		logic [31:0]          spec_ang;
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] s;
		logic [31:0]          z;
		logic [63:0]          rem;
		logic [63:0]          root;
	} lane_t;

	// atan(2^-i) as a fraction of a full turn times 2^32
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] a;
		case (idx)
			5'd0:    a = 32'h2000_0000;
			5'd1:    a = 32'h12E4_051E;
			5'd2:    a = 32'h09FB_385B;
			5'd3:    a = 32'h0511_11D4;
			5'd4:    a = 32'h028B_0D43;
			5'd5:    a = 32'h0145_D7E1;
			5'd6:    a = 32'h00A2_F61E;
			5'd7:    a = 32'h0051_7C55;
			5'd8:    a = 32'h0028_BE53;
			5'd9:    a = 32'h0014_5F2F;
			5'd10:   a = 32'h000A_2F98;
			5'd11:   a = 32'h0005_17CC;
			5'd12:   a = 32'h0002_8BE6;
			5'd13:   a = 32'h0001_45F3;
			5'd14:   a = 32'h0000_A2FA;
			5'd15:   a = 32'h0000_517D;
			5'd16:   a = 32'h0000_28BE;
			5'd17:   a = 32'h0000_145F;
			5'd18:   a = 32'h0000_0A30;
			5'd19:   a = 32'h0000_0518;
			5'd20:   a = 32'h0000_028C;
			5'd21:   a = 32'h0000_0146;
			5'd22:   a = 32'h0000_00A3;
			5'd23:   a = 32'h0000_0051;
			5'd24:   a = 32'h0000_0029;
			5'd25:   a = 32'h0000_0014;
			5'd26:   a = 32'h0000_000A;
			5'd27:   a = 32'h0000_0005;
			5'd28:   a = 32'h0000_0003;
			5'd29:   a = 32'h0000_0001;
			5'd30:   a = 32'h0000_0001;
			default: a = 32'h0000_0000;
		endcase
		return a;
	endfunction

endpackage

// ===== hdl/cpc_prep.sv =====
// Front stages: operand setup, squaring and sum for the root.
module cpc_prep (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  mode,
	input  logic signed [31:0]    coord_x,
	input  logic signed [31:0]    coord_y,
	input  logic [30:0]           magnitude_in,
	input  logic [31:0]           angle_in,
	output logic                  out_valid,
	output cpc_pkg::lane_t        out_lane
);
	import cpc_pkg::*;

	logic signed [CW-1:0] u_ext;
	logic signed [CW-1:0] v_ext;
	logic                 flip;
	logic [31:0]          ax;
	logic [31:0]          ay;
	lane_t                lane0;
	lane_t                lane_sum;

	logic        valid_s1;
	lane_t       lane_s1;
	logic [31:0] ax_s1;
	logic [31:0] ay_s1;

	logic        valid_s2;
	lane_t       lane_s2;
	logic [63:0] sqx_s2;
	logic [63:0] sqy_s2;

	logic        valid_s3;
	lane_t       lane_s3;

	assign u_ext = CW'(coord_y) <<< GUARD_SHIFT;
	assign v_ext = CW'(coord_x) <<< GUARD_SHIFT;
	// bearing in the second or third quarter: start from the far side
	assign flip  = angle_in[31] ^ angle_in[30];
	assign ax    = coord_x[31] ? -coord_x : coord_x;
	assign ay    = coord_y[31] ? -coord_y : coord_y;

	always_comb begin
		lane0          = '0;
		lane0.mode     = mode;
		lane0.x        = coord_x;
		lane0.y        = coord_y;
		lane0.r        = magnitude_in;
		lane0.t        = angle_in;
		if (!mode) begin
			// axis vectors get exact bearings
			lane0.special = (coord_x == '0) || (coord_y == '0);
			if (coord_x == '0) begin
				lane0.spec_ang = coord_y[31] ? TURN_HALF : '0;
			end else if (coord_y == '0) begin
				lane0.spec_ang = coord_x[31] ? TURN_3QUARTER : TURN_QUARTER;
			end
			// fold into the right half plane
			if (coord_y[31]) begin
				lane0.c = -u_ext;
				lane0.s = -v_ext;
				lane0.z = TURN_HALF;
			end else begin
				lane0.c = u_ext;
				lane0.s = v_ext;
				lane0.z = '0;
			end
		end else begin
			lane0.c = flip ? -INV_GAIN : INV_GAIN;
			lane0.s = '0;
			lane0.z = flip ? angle_in - TURN_HALF : angle_in;
		end
	end

	// root seed: remainder is the sum of squares, root starts at zero
	always_comb begin
		lane_sum      = lane_s2;
		lane_sum.rem  = sqx_s2 + sqy_s2;
		lane_sum.root = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			lane_s1 <= lane0;
			ax_s1   <= ax;
			ay_s1   <= ay;
		end
		if (valid_s1) begin
			lane_s2 <= lane_s1;
			sqx_s2  <= 64'(ax_s1) * 64'(ax_s1);
			sqy_s2  <= 64'(ay_s1) * 64'(ay_s1);
		end
		if (valid_s2) begin
			lane_s3 <= lane_sum;
		end
	end

	assign out_valid = valid_s3;
	assign out_lane  = lane_s3;

endmodule

// ===== hdl/cpc_step.sv =====
// One pipeline step: a square-root digit and, when ROTATE is set, a CORDIC micro-rotation.
module cpc_step #(
	parameter int IDX    = 0,
	parameter bit ROTATE = 1'b1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  cpc_pkg::lane_t in_lane,
	output logic           out_valid,
	output cpc_pkg::lane_t out_lane
);
	import cpc_pkg::*;

	localparam logic [63:0] SQ_BIT = 64'(1) << (62 - 2 * IDX);

	logic [64:0]          trial;
	logic                 take;
	logic signed [CW-1:0] c_cur;
	logic signed [CW-1:0] s_cur;
	logic signed [CW-1:0] c_nxt;
	logic signed [CW-1:0] s_nxt;
	logic [31:0]          z_nxt;
	lane_t                nxt;

	logic  valid_s1;
	lane_t lane_s1;

	assign c_cur = in_lane.c;
	assign s_cur = in_lane.s;

	// restoring root digit: try root + bit against the remainder
	assign trial = {1'b0, in_lane.root} + {1'b0, SQ_BIT};
	assign take  = {1'b0, in_lane.rem} >= trial;

	if (ROTATE) begin : g_rot
		localparam logic [31:0] ANG = atan_turn(5'(IDX));
		logic signed [CW-1:0] dc;
		logic signed [CW-1:0] ds;
		logic                 neg;
		assign dc    = s_cur >>> IDX;
		assign ds    = c_cur >>> IDX;
		// vectoring drives s to zero, rotation drives z to zero
		assign neg   = in_lane.mode ? in_lane.z[31] : (!s_cur[CW-1] && (s_cur != '0));
		assign c_nxt = neg ? c_cur + dc : c_cur - dc;
		assign s_nxt = neg ? s_cur - ds : s_cur + ds;
		assign z_nxt = neg ? in_lane.z + ANG : in_lane.z - ANG;
	end else begin : g_hold
		assign c_nxt = c_cur;
		assign s_nxt = s_cur;
		assign z_nxt = in_lane.z;
	end

	always_comb begin
		nxt      = in_lane;
		nxt.c    = c_nxt;
		nxt.s    = s_nxt;
		nxt.z    = z_nxt;
		nxt.rem  = take ? in_lane.rem - trial[63:0] : in_lane.rem;
		nxt.root = take ? (in_lane.root >> 1) + SQ_BIT : in_lane.root >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			lane_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_lane  = lane_s1;

endmodule

// ===== hdl/cpc_post.sv =====
// Back stages: root rounding, bearing select, length scaling and saturation.
module cpc_post (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  cpc_pkg::lane_t     in_lane,
	output logic               done,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic [31:0]        out_magnitude,
	output logic [31:0]        out_angle
);
	import cpc_pkg::*;

	localparam int MAG_W  = 34;
	localparam int SPLIT  = 17;
	localparam int HI_W   = MAG_W - SPLIT;
	localparam int LO_P_W = 31 + SPLIT;
	localparam int HI_P_W = 31 + HI_W;
	localparam int PROD_W = 31 + MAG_W + 1;

	function automatic logic [31:0] sat_coord(input logic [PROD_W-1:0] prod, input logic neg);
		logic [PROD_W-1:0] rnd;
		logic [PROD_W-33:0] p;
		logic [31:0]        res;
		rnd = prod + PROD_W'(32'h8000_0000);
		p   = rnd[PROD_W-1:32];
		if (neg) begin
			res = (p > (PROD_W-32)'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000 : 32'(-p);
		end else begin
			res = (p > (PROD_W-32)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : p[31:0];
		end
		return res;
	endfunction

	logic signed [CW-1:0] s_in;
	logic signed [CW-1:0] c_in;
	logic signed [CW-1:0] abs_s;
	logic signed [CW-1:0] abs_c;
	logic [31:0]          mag_rnd;

	logic              valid_s1;
	logic              mode_s1;
	logic signed [31:0] x_s1;
	logic signed [31:0] y_s1;
	logic [30:0]       r_s1;
	logic [31:0]       t_s1;
	logic [31:0]       mag_s1;
	logic [31:0]       ang_s1;
	logic              negx_s1;
	logic              negy_s1;
	logic [HI_W-1:0]   hix_s1;
	logic [HI_W-1:0]   hiy_s1;
	logic [LO_P_W-1:0] lox_s1;
	logic [LO_P_W-1:0] loy_s1;

	logic [HI_P_W-1:0] hi_px;
	logic [HI_P_W-1:0] hi_py;

	logic               valid_s2;
	logic               mode_s2;
	logic signed [31:0] x_s2;
	logic signed [31:0] y_s2;
	logic [30:0]        r_s2;
	logic [31:0]        t_s2;
	logic [31:0]        mag_s2;
	logic [31:0]        ang_s2;
	logic               negx_s2;
	logic               negy_s2;
	logic [PROD_W-1:0]  prodx_s2;
	logic [PROD_W-1:0]  prody_s2;

	logic               done_s3;
	logic signed [31:0] x_s3;
	logic signed [31:0] y_s3;
	logic [31:0]        mag_s3;
	logic [31:0]        ang_s3;

	assign s_in  = in_lane.s;
	assign c_in  = in_lane.c;
	assign abs_s = s_in[CW-1] ? -s_in : s_in;
	assign abs_c = c_in[CW-1] ? -c_in : c_in;
	// round to nearest: bump when the remainder exceeds the root
	assign mag_rnd = in_lane.root[31:0] + 32'(in_lane.rem > in_lane.root);

	assign hi_px = HI_P_W'(r_s1) * HI_P_W'(hix_s1);
	assign hi_py = HI_P_W'(r_s1) * HI_P_W'(hiy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_s3  <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			done_s3  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			mode_s1 <= in_lane.mode;
			x_s1    <= in_lane.x;
			y_s1    <= in_lane.y;
			r_s1    <= in_lane.r;
			t_s1    <= in_lane.t;
			mag_s1  <= mag_rnd;
			ang_s1  <= in_lane.special ? in_lane.spec_ang : in_lane.z;
			negx_s1 <= s_in[CW-1];
			negy_s1 <= c_in[CW-1];
			hix_s1  <= abs_s[MAG_W-1:SPLIT];
			hiy_s1  <= abs_c[MAG_W-1:SPLIT];
			lox_s1  <= LO_P_W'(in_lane.r) * LO_P_W'(abs_s[SPLIT-1:0]);
			loy_s1  <= LO_P_W'(in_lane.r) * LO_P_W'(abs_c[SPLIT-1:0]);
		end
		if (valid_s1) begin
			mode_s2  <= mode_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			r_s2     <= r_s1;
			t_s2     <= t_s1;
			mag_s2   <= mag_s1;
			ang_s2   <= ang_s1;
			negx_s2  <= negx_s1;
			negy_s2  <= negy_s1;
			prodx_s2 <= PROD_W'(lox_s1) + (PROD_W'(hi_px) << SPLIT);
			prody_s2 <= PROD_W'(loy_s1) + (PROD_W'(hi_py) << SPLIT);
		end
		if (valid_s2) begin
			if (mode_s2) begin
				x_s3   <= sat_coord(prodx_s2, negx_s2);
				y_s3   <= sat_coord(prody_s2, negy_s2);
				mag_s3 <= 32'(r_s2);
				ang_s3 <= t_s2;
			end else begin
				x_s3   <= x_s2;
				y_s3   <= y_s2;
				mag_s3 <= mag_s2;
				ang_s3 <= ang_s2;
			end
		end
	end

	assign done          = done_s3;
	assign out_x         = x_s3;
	assign out_y         = y_s3;
	assign out_magnitude = mag_s3;
	assign out_angle     = ang_s3;

endmodule

// ===== hdl/cartesian_polar_converter.sv =====
// Top level of the pipelined CORDIC Cartesian/polar converter.
// The converter takes one beat per clock and returns each result in the
// order of the beats, each marked by a one-cycle done pulse.
// busy is held low: the pipeline never stalls, because the receiver cannot
// hold results off and every beat moves one stage per clock. The depth is set
// by the 32 step stages, each resolving one digit of the 32-bit square root;
// the first CORDIC_STAGES of them also carry one CORDIC micro-rotation, the
// rest pass the angle lanes through. Mode 0 returns x and y with the rounded
// length and the bearing clockwise from +y as a fraction of a turn times 2^32;
// mode 1 returns r*sin and r*cos, saturated, with r and the bearing echoed.
`include "cartesian_polar_converter_assert.svh"
module cartesian_polar_converter #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic [30:0]        magnitude_in,
	input  logic [31:0]        angle_in,
	output logic               done,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic [31:0]        out_magnitude,
	output logic [31:0]        out_angle
);
	import cpc_pkg::*;

	// start to done, fixed for every beat
	localparam int LATENCY = PREP_STAGES + SQRT_STEPS + POST_STAGES;

	logic  accept;
	logic  step_valid [SQRT_STEPS+1];
	lane_t step_lane  [SQRT_STEPS+1];

	// no backpressure anywhere, so a beat is taken whenever start is high
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// setup, squares of |x| and |y|, and their sum for the root
	cpc_prep u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (accept),
		.mode         (mode),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.magnitude_in (magnitude_in),
		.angle_in     (angle_in),
		.out_valid    (step_valid[0]),
		.out_lane     (step_lane[0])
	);

	// unrolled step chain; valid travels with each lane
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		cpc_step #(
			.IDX    (k),
			.ROTATE (k < CORDIC_STAGES)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (step_valid[k]),
			.in_lane   (step_lane[k]),
			.out_valid (step_valid[k+1]),
			.out_lane  (step_lane[k+1])
		);
	end

	// rounding, bearing select, r times sin/cos and saturation
	cpc_post u_post (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (step_valid[SQRT_STEPS]),
		.in_lane       (step_lane[SQRT_STEPS]),
		.done          (done),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_magnitude (out_magnitude),
		.out_angle     (out_angle)
	);

	// a result only ever follows an accepted beat, a fixed latency later
	`CPC_ASSERT_IMPLY(a_done_latency, clk, arst_n, done, $past(accept, LATENCY), "done w/o beat")
	// back-to-back beats come out back to back
	`CPC_ASSERT_NEXT(a_done_train, clk, arst_n, done, done == $past(accept, LATENCY), "gap")
	// polar beats echo the bearing they came in with
	`CPC_ASSERT_IMPLY(a_polar_echo, clk, arst_n, done && $past(mode, LATENCY),
		out_angle == $past(angle_in, LATENCY), "echo")
	// zero vector gives zero length and zero bearing
	`CPC_ASSERT_IMPLY(a_zero_vec, clk, arst_n,
		done && $past(!mode && coord_x == 0 && coord_y == 0, LATENCY),
		out_angle == 32'd0 && out_magnitude == 32'd0, "zero")

endmodule
